// ===== sv/s2d_pkg.sv =====
package s2d_pkg;

  localparam int MagWidth  = 32;
  localparam int NumDigits = 10;
  localparam int BcdWidth  = 4 * NumDigits;
  localparam int CntWidth  = $clog2(MagWidth);
  localparam int IdxWidth  = $clog2(NumDigits);

  localparam logic [7:0] AsciiZero  = 8'd48;
  localparam logic [7:0] AsciiMinus = 8'd45;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGIT
  } state_t;

endpackage

// ===== sv/signed_int_to_decimal_ascii_core.sv =====
// sequence: once the request is taken, the bcd converter runs 32 shift-add-3
// steps and raises its done flag, the leading digit is picked, and then the
// first character is loaded into the output register
// requests: a new one is taken only in idle, once the last of its n characters
// (1 to 11) is loaded; stalls from char_ready hold this back
// reset: synchronous, active high; returns to idle and drops char_valid
module signed_int_to_decimal_ascii_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                value_valid,
  output logic                                value_ready,
  input  logic signed [s2d_pkg::MagWidth-1:0] value,
  output logic                                char_valid,
  input  logic                                char_ready,
  output logic [7:0]                          ascii_char,
  output logic                                last_char
);

  s2d_pkg::state_t state, state_next;

  logic                         neg;
  logic [s2d_pkg::IdxWidth-1:0] idx, idx_next;
  logic [s2d_pkg::MagWidth-1:0] raw;
  logic [s2d_pkg::MagWidth-1:0] mag;
  logic                         start;
  logic                         done;
  logic [s2d_pkg::BcdWidth-1:0] bcd;
  logic [s2d_pkg::IdxWidth-1:0] msd;
  logic [3:0]                   digit;
  logic                         free;
  logic                         load;
  logic [7:0]                   char_next;
  logic                         last_next;

  assign raw = value;
  assign mag = raw[s2d_pkg::MagWidth-1] ? (~raw + 1'b1) : raw;

  s2d_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mag   (mag),
    .done  (done),
    .bcd   (bcd)
  );

  // highest nonzero digit, zero prints as one digit
  always_comb begin
    msd = '0;
    for (int i = 0; i < s2d_pkg::NumDigits; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        msd = s2d_pkg::IdxWidth'(i);
      end
    end
  end

  assign digit = bcd[{idx, 2'b00} +: 4];
  assign free  = !char_valid || char_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= s2d_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    value_ready = 1'b0;
    start       = 1'b0;
    load        = 1'b0;
    char_next   = s2d_pkg::AsciiZero;
    last_next   = 1'b0;
    case (state)
      s2d_pkg::ST_IDLE: begin
        value_ready = 1'b1;
        if (value_valid) begin
          start      = 1'b1;
          state_next = s2d_pkg::ST_CONV;
        end
      end
      s2d_pkg::ST_CONV: begin
        if (done) begin
          idx_next   = msd;
          state_next = neg ? s2d_pkg::ST_SIGN : s2d_pkg::ST_DIGIT;
        end
      end
      s2d_pkg::ST_SIGN: begin
        if (free) begin
          load       = 1'b1;
          char_next  = s2d_pkg::AsciiMinus;
          state_next = s2d_pkg::ST_DIGIT;
        end
      end
      s2d_pkg::ST_DIGIT: begin
        if (free) begin
          load      = 1'b1;
          char_next = s2d_pkg::AsciiZero + {4'd0, digit};
          last_next = (idx == '0);
          if (idx == '0) begin
            state_next = s2d_pkg::ST_IDLE;
          end else begin
            idx_next = idx - 1'b1;
          end
        end
      end
      default: begin
        state_next = s2d_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (start) begin
      neg <= raw[s2d_pkg::MagWidth-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (load) begin
      char_valid <= 1'b1;
    end else if (char_ready) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ascii_char <= char_next;
      last_char  <= last_next;
    end
  end

endmodule

// ===== sv/s2d_dabble.sv =====
module s2d_dabble (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [s2d_pkg::MagWidth-1:0]  mag,
  output logic                          done,
  output logic [s2d_pkg::BcdWidth-1:0]  bcd
);

  logic [s2d_pkg::MagWidth-1:0] sh;
  logic [s2d_pkg::CntWidth-1:0] cnt;
  logic                         busy;
  logic [s2d_pkg::BcdWidth-1:0] adj;

  // add 3 to every bcd digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < s2d_pkg::NumDigits; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == s2d_pkg::CntWidth'(s2d_pkg::MagWidth - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= mag;
      bcd <= '0;
    end else if (busy) begin
      bcd <= {adj[s2d_pkg::BcdWidth-2:0], sh[s2d_pkg::MagWidth-1]};
      sh  <= {sh[s2d_pkg::MagWidth-2:0], 1'b0};
    end
  end

endmodule
